// File: src/ssms_pkg.sv
package ssms_pkg;

	// Fixed field widths of the stream payloads.
	localparam int PRICE_W = 31;
	localparam int SPAN_W = 11;
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 16;

	// Default series length limit.
	localparam int MAX_DAYS_DEF = 1024;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // capture the accepted request and start the search
		logic pop;     // drop the top stack entry
		logic finish;  // push the new day, load the result, apply end of series
	} ssms_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic pop_ok;    // request not rejected, top entry exists and its price is at most the new price
		logic out_free;  // the result register can take a result at this edge
	} ssms_status_t;

endpackage

// File: src/stock_span_monotonic_stack.sv
// Stock span unit. Each request on the slave stream carries one day's price in
// s_tdata and an end-of-series mark in s_tlast; for each one the master stream
// returns exactly one result with the day's span (the number of consecutive
// days up to and including today whose price is at most today's) and a flag
// that is set when the series already held MAX_DAYS days, in which case the
// span is 0 and the stack is left alone. Prices live on a stack in a
// single-port-write, single-port-read memory of MAX_DAYS entries with
// registered read data. A request is loaded, pops stack entries while the top
// price is at most its own, and then finishes; each day is pushed once and
// popped at most once, the pop loop being bounded by the one memory read per
// cycle. A finished result waits in an output register, and the next request
// is taken while that result is being drained. After the request that carries
// s_tlast the stack and the day count clear at once, with no sweep of the
// memory; reset likewise needs no clearing pass.
module stock_span_monotonic_stack #(
	parameter int MAX_DAYS = ssms_pkg::MAX_DAYS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// s_tdata: [30:0] price, [31] zero fill
	input  logic [ssms_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic                           s_tlast,   // last_day
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// m_tdata: [10:0] span, [15:11] zero fill
	output logic [ssms_pkg::M_TDATA_W-1:0] m_tdata,
	// m_tuser: [0] rejected
	output logic                           m_tuser
);
	import ssms_pkg::*;

	ssms_cmd_t         cmd;
	ssms_status_t      status;
	logic [SPAN_W-1:0] span;

	// The controller sequences accept, pop and finish; it never sees payload.
	ssms_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// The datapath holds the stack memory, fill and day counters and the
	// result register.
	ssms_dp #(
		.MAX_DAYS (MAX_DAYS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.price     (s_tdata[PRICE_W-1:0]),
		.last_day  (s_tlast),
		.cmd       (cmd),
		.status    (status),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.span      (span),
		.rejected  (m_tuser)
	);

	assign m_tdata = {{(M_TDATA_W-SPAN_W){1'b0}}, span};

	// A request is only taken when the result register will be free for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |-> (!m_tvalid || m_tready))
		else $error("request accepted while the result register is blocked");

	// Only one request is in flight: after an accept the slave side is busy.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second request accepted during a search");

	// A result appears only from the finish step of the controller.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(cmd.finish))
		else $error("result raised without a finish step");

	// Popping never happens in the same cycle as finishing or loading.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> (!cmd.finish && !cmd.load))
		else $error("conflicting datapath commands");

endmodule

// File: src/ssms_ctrl.sv
module ssms_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  ssms_pkg::ssms_status_t status,
	output ssms_pkg::ssms_cmd_t    cmd
);
	import ssms_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_CMP  = 2'b10
	} ssms_state_t;

	ssms_state_t state_q;
	ssms_state_t state_d;

	assign s_tready = (state_q == ST_IDLE) && status.out_free;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid && s_tready) begin
					cmd.load = 1'b1;
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				// One entry is popped per cycle until the top holds a higher price.
				if (status.pop_ok) begin
					cmd.pop = 1'b1;
				end else begin
					cmd.finish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: src/ssms_dp.sv
module ssms_dp #(
	parameter int MAX_DAYS = ssms_pkg::MAX_DAYS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [ssms_pkg::PRICE_W-1:0] price,
	input  logic                         last_day,
	input  ssms_pkg::ssms_cmd_t           cmd,
	output ssms_pkg::ssms_status_t        status,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ssms_pkg::SPAN_W-1:0]  span,
	output logic                         rejected
);
	import ssms_pkg::*;

	localparam int DAY_W = $clog2(MAX_DAYS);
	localparam int CNT_W = $clog2(MAX_DAYS + 1);
	localparam int ENT_W = PRICE_W + DAY_W;

	logic [ENT_W-1:0] stack_mem [MAX_DAYS];
	logic [ENT_W-1:0] rd_q;

	logic [PRICE_W-1:0] price_q;
	logic               last_q;
	logic               rej_q;
	logic [CNT_W-1:0]   fill_q;
	logic [CNT_W-1:0]   fill_d;
	logic [CNT_W-1:0]   day_q;
	logic [CNT_W-1:0]   rd_idx;
	logic [DAY_W-1:0]   rd_addr;
	logic               push;

	logic [PRICE_W-1:0]     top_price;
	logic [DAY_W-1:0]       top_day;
	logic [CNT_W-1:0]       span_full;
	logic [SPAN_W+CNT_W-1:0] span_ext;

	logic              out_valid_q;
	logic [SPAN_W-1:0] span_q;
	logic              rej_out_q;

	assign top_price = rd_q[ENT_W-1:DAY_W];
	assign top_day = rd_q[DAY_W-1:0];

	assign status.pop_ok = !rej_q && (fill_q != '0) && (top_price <= price_q);
	assign status.out_free = !out_valid_q || out_ready;

	assign push = cmd.finish && !rej_q;

	always_comb begin
		fill_d = fill_q;
		if (cmd.pop) begin
			fill_d = fill_q - CNT_W'(1);
		end else if (cmd.finish) begin
			if (last_q) begin
				fill_d = '0;
			end else if (!rej_q) begin
				fill_d = fill_q + CNT_W'(1);
			end
		end
	end

	// The read address tracks the entry that will be on top next cycle.
	assign rd_idx = fill_d - CNT_W'(1);
	assign rd_addr = rd_idx[DAY_W-1:0];

	always_ff @(posedge clk) begin
		if (push) begin
			stack_mem[fill_q[DAY_W-1:0]] <= {price_q, day_q[DAY_W-1:0]};
		end
		rd_q <= stack_mem[rd_addr];
	end

	always_comb begin
		if (fill_q == '0) begin
			span_full = day_q + CNT_W'(1);
		end else begin
			span_full = day_q - CNT_W'(top_day);
		end
	end

	assign span_ext = {{SPAN_W{1'b0}}, span_full};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			price_q <= price;
			last_q <= last_day;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			day_q <= '0;
			rej_q <= 1'b0;
		end else begin
			fill_q <= fill_d;
			if (cmd.load) begin
				rej_q <= (day_q >= CNT_W'(MAX_DAYS));
			end
			if (cmd.finish) begin
				if (last_q) begin
					day_q <= '0;
				end else if (!rej_q) begin
					day_q <= day_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			span_q <= rej_q ? '0 : span_ext[SPAN_W-1:0];
			rej_out_q <= rej_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign span = span_q;
	assign rejected = rej_out_q;

endmodule

// File: sim/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ssms_pkg::*;

	localparam int DAYS = MAX_DAYS_DEF;
	localparam bit [PRICE_W-1:0] PRICE_MAX = {PRICE_W{1'b1}};
	localparam int STALL_LIMIT = 20000;

	// How the prices of one series are drawn.
	typedef enum int {
		PM_RANDOM,
		PM_NARROW,
		PM_RISING,
		PM_FALLING,
		PM_TOP
	} price_mode_t;

	typedef struct {
		bit [SPAN_W-1:0] span;
		bit              rejected;
	} span_result_t;

	// Tracks the stack of earlier days the same way the block should, and keeps
	// the spans that are still owed in request order.
	class SpanScoreboard;
		bit [PRICE_W-1:0] stk_price[DAYS];
		bit [9:0]         stk_day[DAYS];
		int unsigned      fill;
		int unsigned      day_count;
		span_result_t     spans_due[$];
		int               errors;

		function new();
			fill = 0;
			day_count = 0;
			errors = 0;
		endfunction

		function int pending();
			return spans_due.size();
		endfunction

		function void note_request(bit [PRICE_W-1:0] price, bit last);
			span_result_t res;
			if (day_count >= DAYS) begin
				// Series already full: nothing is pushed and the count stays put.
				res.span = '0;
				res.rejected = 1'b1;
			end else begin
				// Equal prices pop too, so they add to the span.
				while (fill > 0 && stk_price[fill-1] <= price)
					fill--;
				if (fill == 0)
					res.span = SPAN_W'(day_count + 1);
				else
					res.span = SPAN_W'(day_count - stk_day[fill-1]);
				stk_price[fill] = price;
				stk_day[fill] = day_count[9:0];
				fill++;
				day_count++;
				res.rejected = 1'b0;
			end
			// The series ends even when its last request was rejected.
			if (last) begin
				fill = 0;
				day_count = 0;
			end
			spans_due.insert(spans_due.size(), res);
		endfunction

		function void check_result(logic [M_TDATA_W-1:0] tdata, logic tuser);
			span_result_t exp_res;
			if (spans_due.size() == 0) begin
				$error("result with no request outstanding: span %0d rejected %b",
					tdata[SPAN_W-1:0], tuser);
				errors++;
				return;
			end
			exp_res = spans_due.pop_front();
			if (tdata[SPAN_W-1:0] !== exp_res.span) begin
				$error("span: expected %0d, actual %0d", exp_res.span, tdata[SPAN_W-1:0]);
				errors++;
			end
			if (tuser !== exp_res.rejected) begin
				$error("rejected: expected %b, actual %b", exp_res.rejected, tuser);
				errors++;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic                 s_tlast = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tuser;

	bit            no_idle = 1'b0;
	int            stall_cycles = 0;
	SpanScoreboard sb = new();

	stock_span_monotonic_stack dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The receiver stalls at random, except inside the stretch with no idling.
	always @(posedge clk) begin
		m_tready <= no_idle || ($urandom_range(0, 99) >= 21);
	end

	// Both handshakes are observed with the values from before the edge. The
	// same block counts cycles in which no request and no result moves.
	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			sb.note_request(s_tdata[PRICE_W-1:0], s_tlast);
		if (m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Presents one request and returns at the edge where it is taken.
	task automatic send_day(input bit [PRICE_W-1:0] price, input bit last);
		while (!no_idle && $urandom_range(0, 99) < 21) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, price};
		s_tlast <= last;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	function automatic bit [PRICE_W-1:0] pick_price(price_mode_t mode,
		bit [PRICE_W-1:0] prev);
		bit [PRICE_W-1:0] p;
		case (mode)
			PM_RANDOM: p = PRICE_W'($urandom);
			PM_NARROW: p = PRICE_W'($urandom_range(0, 7));
			PM_RISING: p = (prev > PRICE_MAX - 3) ? prev : prev + PRICE_W'($urandom_range(0, 3));
			PM_FALLING: p = (prev < 3) ? prev : prev - PRICE_W'($urandom_range(0, 3));
			default: p = PRICE_MAX - PRICE_W'($urandom_range(0, 3));
		endcase
		return p;
	endfunction

	// One series of len days, the last one flagged as the end of the series.
	task automatic send_series(input int len, input price_mode_t mode);
		bit [PRICE_W-1:0] p;
		case (mode)
			PM_RISING: p = PRICE_W'($urandom_range(0, 1 << 20));
			PM_FALLING: p = PRICE_MAX - PRICE_W'($urandom_range(0, 1 << 20));
			default: p = '0;
		endcase
		for (int i = 0; i < len; i++) begin
			p = pick_price(mode, p);
			send_day(p, i == len - 1);
		end
	endtask

	initial begin
		int series_no;
		int sent_items;
		int len;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A lone day at the lowest price.
		send_day('0, 1'b1);
		// Extremes of the price, equal prices that pop, and a final maximum
		// that clears the whole stack.
		send_day(PRICE_MAX, 1'b0);
		send_day('0, 1'b0);
		send_day('0, 1'b0);
		send_day(31'd5, 1'b0);
		send_day(31'd3, 1'b0);
		send_day(31'd3, 1'b0);
		send_day(31'd7, 1'b0);
		send_day(PRICE_MAX, 1'b1);
		// Falling prices keep every day on the stack until a repeated price pops its equal.
		send_day(31'd100, 1'b0);
		send_day(31'd90, 1'b0);
		send_day(31'd80, 1'b0);
		send_day(31'd80, 1'b1);
		// Alternating bit patterns.
		send_day(31'h2AAAAAAA, 1'b0);
		send_day(31'h55555555, 1'b0);
		send_day(31'h55555555, 1'b1);
		wait_drained();

		// Mostly short series with varied price shapes. One series rises for
		// a full MAX_DAYS, reaching the largest span, then runs into rejected
		// days and ends on one.
		series_no = 0;
		sent_items = 16;
		while (sent_items < 2000) begin
			no_idle = (series_no >= 20 && series_no < 40);
			if (series_no == 5) begin
				send_series(DAYS + 3, PM_RISING);
				sent_items += DAYS + 3;
			end else begin
				len = $urandom_range(1, 40);
				send_series(len, price_mode_t'($urandom_range(0, 4)));
				sent_items += len;
			end
			if (series_no == 30)
				wait_drained();
			series_no++;
		end
		no_idle = 1'b0;

		wait_drained();
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
